/* hw/rtl/wcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_pkg
// Shared sizes, register indexes and control types of the window magnitude
// convolution block.
// ----------------------------------------------------------------------------
package wcm_pkg;

    localparam int LINE_MAX   = 1024;
    localparam int FILT_MAX   = 16;
    localparam int LINES_MAX  = 4096;
    localparam int COEF_DEPTH = 256;
    localparam int RING_LINES = FILT_MAX - 1;

    localparam int ROW_W   = $clog2(LINE_MAX);
    localparam int LINE_W  = $clog2(LINES_MAX);
    localparam int FILT_W  = $clog2(FILT_MAX);
    localparam int SLOT_W  = $clog2(RING_LINES);
    localparam int LEN_W   = ROW_W + 1;
    localparam int EXT_W   = FILT_W + 1;
    localparam int IDX_W   = 2 * FILT_W + 1;
    localparam int CIDX_W  = $clog2(COEF_DEPTH);

    localparam int LS_DEPTH  = RING_LINES * LINE_MAX;
    localparam int LS_AW     = $clog2(LS_DEPTH);
    localparam int WIN_AW    = 2 * FILT_W;
    localparam int WIN_DEPTH = 1 << WIN_AW;

    localparam int MAG_W  = 16;
    localparam int COEF_W = 15;
    localparam int PROD_W = MAG_W + COEF_W;
    localparam int RESP_W = 39;

    localparam int CFG_W    = 11;
    localparam int CFG_IX_W = 2;

    localparam logic [CFG_IX_W-1:0] CFG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_FILTER_ROWS = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_FILTER_COLS = 2'd2;

    localparam logic ACT_COEF  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef struct packed {
        logic clear;
        logic valid;
        logic coef_ok;
    } mac_ctl_t;

endpackage

/* hw/rtl/wcm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hw/rtl/wcm_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcm_mac
// Two-stage multiply-accumulate: registered product, then running sum.
// ----------------------------------------------------------------------------
module wcm_mac (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wcm_pkg::mac_ctl_t        ctl,
    input  logic [wcm_pkg::COEF_W-1:0] coef,
    input  logic [wcm_pkg::MAG_W-1:0]  pix,
    output logic                     busy,
    output logic [wcm_pkg::RESP_W-1:0] acc
);
    import wcm_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              pvalid_reg;
    logic [RESP_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        // out-of-store coefficient slots count as zero
        prod_reg <= ctl.coef_ok ? PROD_W'(coef) * PROD_W'(pix) : '0;
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (pvalid_reg)
        begin
            acc_reg <= acc_reg + RESP_W'(prod_reg);
        end
    end

    assign busy = pvalid_reg;
    assign acc  = acc_reg;

endmodule

/* hw/rtl/window_conv_max_abs_channel_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_conv_max_abs_channel_unit
// Window magnitude convolution over a three-channel raster pixel stream.
// ----------------------------------------------------------------------------
// A coefficient beat is written to the coefficient store when it is taken. A
// pixel beat moves the new window column out of the line store into the window
// memory (one line-store access per cycle) and, when it completes a window, then
// runs the multiply-accumulate loop (one window cell and one coefficient read per
// cycle), waits for the accumulator to drain and loads the result register. The
// input stalls while a pixel is in work; a finished result waits in its own
// register while the next beat is taken.
// The stores come up undefined and need no clearing pass.
module window_conv_max_abs_channel_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [wcm_pkg::CFG_IX_W-1:0]  cfg_index,
    input  logic [wcm_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [7:0]                    coef_index,
    input  logic signed [15:0]            coef_value,
    input  logic signed [15:0]            chan_a,
    input  logic signed [15:0]            chan_b,
    input  logic signed [15:0]            chan_c,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [38:0]                   response,
    output logic [9:0]                    centre_row,
    output logic [11:0]                   centre_line
);
    import wcm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LINE,
        ST_SUM,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFG_W-1:0] line_length_reg;
    logic [EXT_W-1:0] filter_rows_reg;
    logic [EXT_W-1:0] filter_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= CFG_W'(1024);
            filter_rows_reg <= EXT_W'(3);
            filter_cols_reg <= EXT_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_LENGTH: line_length_reg <= cfg_data;
                CFG_FILTER_ROWS: filter_rows_reg <= cfg_data[EXT_W-1:0];
                CFG_FILTER_COLS: filter_cols_reg <= cfg_data[EXT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [LEN_W-1:0] len;
    logic [EXT_W-1:0] m;
    logic [EXT_W-1:0] n;

    always_comb
    begin
        if (line_length_reg == '0)
            len = LEN_W'(1);
        else if (line_length_reg > CFG_W'(LINE_MAX))
            len = LEN_W'(LINE_MAX);
        else
            len = LEN_W'(line_length_reg);
        if (filter_rows_reg == '0)
            m = EXT_W'(1);
        else if (filter_rows_reg > EXT_W'(FILT_MAX))
            m = EXT_W'(FILT_MAX);
        else
            m = filter_rows_reg;
        if (filter_cols_reg == '0)
            n = EXT_W'(1);
        else if (filter_cols_reg > EXT_W'(FILT_MAX))
            n = EXT_W'(FILT_MAX);
        else
            n = filter_cols_reg;
    end

    // input decode
    logic accept;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    function automatic logic [MAG_W-1:0] mag16(input logic signed [15:0] v);
        logic [MAG_W-1:0] r;
        r = v[15] ? MAG_W'(-v) : MAG_W'(v);
        return r;
    endfunction

    logic [MAG_W-1:0]  ma, mb, mc, mag;
    logic [MAG_W-1:0]  cmag;
    logic [COEF_W-1:0] coef_sat;

    always_comb
    begin
        ma  = mag16(chan_a);
        mb  = mag16(chan_b);
        mc  = mag16(chan_c);
        mag = ma;
        if (mb > mag)
            mag = mb;
        if (mc > mag)
            mag = mc;
        cmag = mag16(coef_value);
        coef_sat = cmag[MAG_W-1] ? {COEF_W{1'b1}} : cmag[COEF_W-1:0];
    end

    // raster position
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic [LINE_W-1:0] line_pos_reg, line_pos_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [FILT_W-1:0] colptr_reg;
    logic [ROW_W-1:0]  row_now;
    logic [LINE_W-1:0] line_now;
    logic [SLOT_W-1:0] slot_now;
    logic              emit_now;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = (s == SLOT_W'(RING_LINES - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
        logic [LINE_W-1:0] r;
        r = (l == LINE_W'(LINES_MAX - 1)) ? l : l + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        row_now  = frame_start ? '0 : row_pos_reg;
        line_now = frame_start ? '0 : line_pos_reg;
        slot_now = frame_start ? '0 : slot_reg;
        // a shrunk line length starts a new line first
        if (LEN_W'(row_now) >= len)
        begin
            row_now  = '0;
            line_now = line_inc(line_now);
            slot_now = slot_inc(slot_now);
        end
        emit_now = (EXT_W'(row_now) + 1'b1 >= m || row_now >= ROW_W'(FILT_MAX))
                && (EXT_W'(line_now) + 1'b1 >= n || line_now >= LINE_W'(FILT_MAX));
        if (LEN_W'(row_now) + 1'b1 >= len)
        begin
            row_pos_next  = '0;
            line_pos_next = line_inc(line_now);
            slot_next     = slot_inc(slot_now);
        end
        else
        begin
            row_pos_next  = row_now + 1'b1;
            line_pos_next = line_now;
            slot_next     = slot_now;
        end
    end

    // current pixel, held for the whole pixel pass
    logic [ROW_W-1:0]  cur_row_reg;
    logic [LINE_W-1:0] cur_line_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [MAG_W-1:0]  cur_mag_reg;
    logic              cur_emit_reg;

    // sequencer counters
    logic [FILT_W-1:0] cnt_reg;
    logic [FILT_W-1:0] si_reg, sd_reg;
    logic [IDX_W-1:0]  base_reg, idx_reg;
    logic              s1_valid_reg, s1_ok_reg;
    logic              last_issue;

    // output register
    logic              out_valid_reg;
    logic [RESP_W-1:0] response_reg;
    logic [9:0]        centre_row_reg;
    logic [11:0]       centre_line_reg;

    logic              mac_busy;
    logic [RESP_W-1:0] mac_acc;
    mac_ctl_t          mac_ctl;

    logic [IDX_W-1:0]  mn;
    assign mn = IDX_W'(m) * IDX_W'(n);
    assign last_issue = (EXT_W'(sd_reg) == n - 1'b1) && (EXT_W'(si_reg) == m - 1'b1);

    // ring slot that held line (current - d)
    logic [FILT_W-1:0] rd_d;
    logic [SLOT_W-1:0] rd_dd;
    logic [SLOT_W-1:0] rd_slot;

    always_comb
    begin
        rd_d  = cnt_reg + 1'b1;
        rd_dd = (rd_d == FILT_W'(RING_LINES)) ? '0 : SLOT_W'(rd_d);
        if (cur_slot_reg >= rd_dd)
            rd_slot = cur_slot_reg - rd_dd;
        else
            rd_slot = SLOT_W'(SLOT_W'(RING_LINES) + cur_slot_reg - rd_dd);
    end

    // line store port
    logic              ls_we;
    logic [LS_AW-1:0]  ls_addr;
    logic [MAG_W-1:0]  ls_rdata;

    assign ls_we = (state_reg == ST_LINE) && (cnt_reg == FILT_W'(FILT_MAX - 1));

    always_comb
    begin
        if (ls_we)
            ls_addr = LS_AW'(LS_AW'(cur_slot_reg) * LS_AW'(LINE_MAX) + LS_AW'(cur_row_reg));
        else
            ls_addr = LS_AW'(LS_AW'(rd_slot) * LS_AW'(LINE_MAX) + LS_AW'(cur_row_reg));
    end

    wcm_ram #(.WIDTH(MAG_W), .DEPTH(LS_DEPTH)) u_line_store (
        .clk   (clk),
        .we    (ls_we),
        .addr  (ls_addr),
        .wdata (cur_mag_reg),
        .rdata (ls_rdata)
    );

    // window memory: column i of the window lives at colptr - i
    logic              win_we;
    logic [WIN_AW-1:0] win_addr;
    logic [MAG_W-1:0]  win_wdata;
    logic [MAG_W-1:0]  win_rdata;
    logic [FILT_W-1:0] win_col;

    assign win_we    = (state_reg == ST_LINE);
    assign win_wdata = (cnt_reg == '0) ? cur_mag_reg : ls_rdata;
    assign win_col   = colptr_reg - si_reg;
    assign win_addr  = win_we ? {colptr_reg, cnt_reg} : {win_col, sd_reg};

    wcm_ram #(.WIDTH(MAG_W), .DEPTH(WIN_DEPTH)) u_window (
        .clk   (clk),
        .we    (win_we),
        .addr  (win_addr),
        .wdata (win_wdata),
        .rdata (win_rdata)
    );

    // coefficient store
    logic              cf_we;
    logic [CIDX_W-1:0] cf_addr;
    logic [COEF_W-1:0] cf_rdata;

    assign cf_we   = accept && (action == ACT_COEF);
    assign cf_addr = cf_we ? CIDX_W'(coef_index) : idx_reg[CIDX_W-1:0];

    wcm_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_store (
        .clk   (clk),
        .we    (cf_we),
        .addr  (cf_addr),
        .wdata (coef_sat),
        .rdata (cf_rdata)
    );

    assign mac_ctl.clear   = accept && (action == ACT_PIXEL);
    assign mac_ctl.valid   = s1_valid_reg;
    assign mac_ctl.coef_ok = s1_ok_reg;

    wcm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .coef  (cf_rdata),
        .pix   (win_rdata),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    logic [ROW_W:0]    crow;
    logic [LINE_W:0]   cline;

    assign crow  = (ROW_W + 1)'(cur_row_reg) + 1'b1 - (ROW_W + 1)'(m)
                 + (ROW_W + 1)'(m >> 1);
    assign cline = (LINE_W + 1)'(cur_line_reg) + 1'b1 - (LINE_W + 1)'(n)
                 + (LINE_W + 1)'(n >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            row_pos_reg     <= '0;
            line_pos_reg    <= '0;
            slot_reg        <= '0;
            colptr_reg      <= '0;
            cnt_reg         <= '0;
            si_reg          <= '0;
            sd_reg          <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            response_reg    <= '0;
            centre_row_reg  <= '0;
            centre_line_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= (state_reg == ST_SUM);
            // drop a taken result unless the emit step refills the register
            if (out_valid_reg && !out_stall && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && action == ACT_PIXEL)
                    begin
                        row_pos_reg  <= row_pos_next;
                        line_pos_reg <= line_pos_next;
                        slot_reg     <= slot_next;
                        colptr_reg   <= colptr_reg + 1'b1;
                        cnt_reg      <= '0;
                        state_reg    <= ST_LINE;
                    end
                end
                ST_LINE:
                begin
                    if (cnt_reg == FILT_W'(FILT_MAX - 1))
                    begin
                        si_reg    <= '0;
                        sd_reg    <= '0;
                        state_reg <= cur_emit_reg ? ST_SUM : ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SUM:
                begin
                    if (last_issue)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else if (EXT_W'(sd_reg) == n - 1'b1)
                    begin
                        sd_reg <= '0;
                        si_reg <= si_reg + 1'b1;
                    end
                    else
                    begin
                        sd_reg <= sd_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (!s1_valid_reg && !mac_busy)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        response_reg    <= mac_acc;
                        centre_row_reg  <= crow[9:0];
                        centre_line_reg <= (cline > (LINE_W + 1)'(4095)) ?
                                           12'd4095 : cline[11:0];
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_ok_reg <= (idx_reg < IDX_W'(COEF_DEPTH));
        if (accept && action == ACT_PIXEL)
        begin
            cur_row_reg  <= row_now;
            cur_line_reg <= line_now;
            cur_slot_reg <= slot_now;
            cur_mag_reg  <= mag;
            cur_emit_reg <= emit_now;
        end
        if (state_reg == ST_LINE)
        begin
            base_reg <= mn - 1'b1;
            idx_reg  <= mn - 1'b1;
        end
        else if (state_reg == ST_SUM)
        begin
            if (EXT_W'(sd_reg) == n - 1'b1)
            begin
                base_reg <= base_reg - 1'b1;
                idx_reg  <= base_reg - 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg - IDX_W'(m);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign response    = response_reg;
    assign centre_row  = centre_row_reg;
    assign centre_line = centre_line_reg;

    a_emit_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result loaded outside emit step");

    a_ls_write_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        ls_we |=> (state_reg == ST_IDLE || state_reg == ST_SUM))
        else $error("line store write not at end of column pass");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM || state_reg == ST_DRAIN) |-> !accept)
        else $error("beat accepted during accumulation");

endmodule
